>>> rtl/acl_pkg.sv
// Shared types and constants of the arm CAN link frame handler.
// No dependencies; the design files refer to this package by scoped names, the testbench imports it.
package acl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W   = 11;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int POS_W  = 16;
  localparam int CMP_W  = 48;   // bytes 0-5 take part in the duplicate check

  localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;

  localparam logic [ID_W-1:0] ID_GROUP_ONE = 11'h350;
  localparam logic [ID_W-1:0] ID_GROUP_TWO = 11'h360;
  localparam logic [ID_W-1:0] ID_POLL      = 11'h37F;

  localparam logic [ID_W-1:0] CARTESIAN_RESET = 11'd1;
  localparam logic [ID_W-1:0] JOINT_RESET     = 11'd4;

  localparam logic CMD_ENQUEUE = 1'b0;

  localparam logic CFG_CARTESIAN = 1'b0;
  localparam logic CFG_JOINT     = 1'b1;

  typedef enum logic [2:0] {
    KIND_QUEUED    = 3'd0,
    KIND_DUPLICATE = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_GROUP_ONE = 3'd3,
    KIND_GROUP_TWO = 3'd4,
    KIND_TRANSMIT  = 3'd5,
    KIND_UNKNOWN   = 3'd6
  } result_kind_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             mode_we;
    logic             valid_set;
    logic [LEN_W-1:0] push_len;
  } ctrl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [ID_W-1:0]   newest_id;
    logic [CMP_W-1:0]  newest_data;
    logic [ID_W-1:0]   head_id;
    logic [LEN_W-1:0]  head_len;
    logic [DATA_W-1:0] head_data;
  } qstat_t;

  typedef struct packed {
    result_kind_t       kind;
    logic signed [15:0] pos_a;
    logic signed [15:0] pos_b;
    logic signed [15:0] pos_c;
    logic signed [15:0] pos_d;
    logic [7:0]         status_code;
    logic [7:0]         message_code;
    logic               state_valid;
    logic               tx_valid;
    logic [ID_W-1:0]    tx_id;
    logic [LEN_W-1:0]   tx_len;
    logic [DATA_W-1:0]  tx_data;
  } result_t;

endpackage

>>> rtl/acl_if.sv
// Valid/ready channel interfaces for frames in and results out.
// Depends on acl_pkg for field widths.
interface acl_frame_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [acl_pkg::ID_W-1:0]     frame_id;
  logic [acl_pkg::LEN_W-1:0]    frame_len;
  logic [acl_pkg::DATA_W-1:0]   frame_data;

  modport source (output valid, command, frame_id, frame_len, frame_data, input ready);
  modport sink   (input valid, command, frame_id, frame_len, frame_data, output ready);
endinterface

interface acl_result_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   result_kind;
  logic signed [15:0]           pos_a;
  logic signed [15:0]           pos_b;
  logic signed [15:0]           pos_c;
  logic signed [15:0]           pos_d;
  logic [7:0]                   status_code;
  logic [7:0]                   message_code;
  logic                         state_valid;
  logic                         tx_valid;
  logic [acl_pkg::ID_W-1:0]     tx_id;
  logic [acl_pkg::LEN_W-1:0]    tx_len;
  logic [acl_pkg::DATA_W-1:0]   tx_data;

  modport source (output valid, result_kind, pos_a, pos_b, pos_c, pos_d, status_code,
                  message_code, state_valid, tx_valid, tx_id, tx_len, tx_data,
                  input ready);
  modport sink   (input valid, result_kind, pos_a, pos_b, pos_c, pos_d, status_code,
                  message_code, state_valid, tx_valid, tx_id, tx_len, tx_data,
                  output ready);
endinterface

>>> rtl/acl_queue.sv
// Outgoing frame FIFO in flip-flops, plus a copy of the newest entry's key.
// Depends on acl_pkg.
module acl_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  acl_pkg::ctrl_t             ctrl,
  input  logic [acl_pkg::ID_W-1:0]   push_id,
  input  logic [acl_pkg::DATA_W-1:0] push_data,
  output acl_pkg::qstat_t            qstat
);

  logic [acl_pkg::ID_W-1:0]   ids      [acl_pkg::QUEUE_DEPTH];
  logic [acl_pkg::LEN_W-1:0]  lens     [acl_pkg::QUEUE_DEPTH];
  logic [acl_pkg::DATA_W-1:0] payloads [acl_pkg::QUEUE_DEPTH];

  logic [acl_pkg::QPTR_W-1:0] head;
  logic [acl_pkg::QPTR_W-1:0] tail;
  logic [acl_pkg::QCNT_W-1:0] count;
  logic [acl_pkg::ID_W-1:0]   newest_id;
  logic [acl_pkg::CMP_W-1:0]  newest_data;

  function automatic logic [acl_pkg::QPTR_W-1:0] bump(input logic [acl_pkg::QPTR_W-1:0] p);
    return (p == acl_pkg::QPTR_W'(acl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctrl.push) begin
      tail  <= bump(tail);
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      head  <= bump(head);
      count <= count - 1'b1;
    end
  end

  // storage and newest-entry copy: no reset, read only after written
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      ids[tail]      <= push_id;
      lens[tail]     <= ctrl.push_len;
      payloads[tail] <= push_data;
      newest_id      <= push_id;
      newest_data    <= push_data[acl_pkg::CMP_W-1:0];
    end
  end

  always_comb begin
    qstat.empty       = (count == '0);
    qstat.full        = (count == acl_pkg::QCNT_W'(acl_pkg::QUEUE_DEPTH));
    qstat.newest_id   = newest_id;
    qstat.newest_data = newest_data;
    qstat.head_id     = ids[head];
    qstat.head_len    = lens[head];
    qstat.head_data   = payloads[head];
  end

endmodule

>>> rtl/acl_decode.sv
// Per-frame decision logic: queue control, position decode and result build.
// Depends on acl_pkg.
module acl_decode (
  input  logic                       command,
  input  logic [acl_pkg::ID_W-1:0]   frame_id,
  input  logic [acl_pkg::LEN_W-1:0]  frame_len,
  input  logic [acl_pkg::DATA_W-1:0] frame_data,
  input  logic [acl_pkg::ID_W-1:0]   cartesian_mode_id,
  input  logic [acl_pkg::ID_W-1:0]   joint_mode_id,
  input  logic [acl_pkg::ID_W-1:0]   mode_id,
  input  logic                       valid_flag,
  input  acl_pkg::qstat_t            qstat,
  output acl_pkg::ctrl_t             ctrl,
  output acl_pkg::result_t           res
);

  logic motion;
  logic mode_motion;
  logic dup;

  // big-endian byte pair starting at byte k
  function automatic logic signed [15:0] pair_at(input logic [acl_pkg::DATA_W-1:0] d,
                                                 input int k);
    return {d[8*k +: 8], d[8*(k+1) +: 8]};
  endfunction

  always_comb begin
    motion      = (frame_id == cartesian_mode_id) || (frame_id == joint_mode_id);
    mode_motion = (mode_id == cartesian_mode_id) || (mode_id == joint_mode_id);
    dup         = !qstat.empty && motion && (qstat.newest_id == frame_id) &&
                  (qstat.newest_data == frame_data[acl_pkg::CMP_W-1:0]);

    ctrl          = '0;
    ctrl.push_len = (frame_len > acl_pkg::LEN_MAX) ? acl_pkg::LEN_MAX : frame_len;
    res           = '0;
    res.kind      = acl_pkg::KIND_UNKNOWN;

    if (command == acl_pkg::CMD_ENQUEUE) begin
      ctrl.mode_we = 1'b1;
      priority if (dup) begin
        res.kind = acl_pkg::KIND_DUPLICATE;
      end else if (qstat.full) begin
        res.kind = acl_pkg::KIND_FULL;
      end else begin
        ctrl.push = 1'b1;
        res.kind  = acl_pkg::KIND_QUEUED;
      end
    end else begin
      unique case (frame_id)
        acl_pkg::ID_GROUP_ONE: begin
          res.kind         = acl_pkg::KIND_GROUP_ONE;
          res.pos_a        = pair_at(frame_data, 2);
          res.pos_b        = pair_at(frame_data, 4);
          res.pos_c        = pair_at(frame_data, 6);
          res.status_code  = frame_data[7:0];
          res.message_code = frame_data[15:8];
        end
        acl_pkg::ID_GROUP_TWO: begin
          res.kind       = acl_pkg::KIND_GROUP_TWO;
          res.pos_a      = pair_at(frame_data, 0);
          res.pos_b      = pair_at(frame_data, 2);
          res.pos_c      = pair_at(frame_data, 4);
          res.pos_d      = pair_at(frame_data, 6);
          ctrl.valid_set = mode_motion;
        end
        acl_pkg::ID_POLL: begin
          res.kind = acl_pkg::KIND_TRANSMIT;
          if (!qstat.empty) begin
            ctrl.pop     = 1'b1;
            res.tx_valid = 1'b1;
            res.tx_id    = qstat.head_id;
            res.tx_len   = qstat.head_len;
            res.tx_data  = qstat.head_data;
          end
        end
        default: begin
          res.kind = acl_pkg::KIND_UNKNOWN;
        end
      endcase
    end

    res.state_valid = valid_flag | ctrl.valid_set;
  end

endmodule

>>> rtl/arm_can_link_frame_handler.sv
// Top level of the arm CAN link frame handler.
// Depends on acl_pkg, acl_if (acl_frame_if, acl_result_if), acl_queue and acl_decode.

// The block takes one frame item per clock while the result side is not stalled,
// and returns exactly one result item per frame, through the input and output registers.
// Each frame is captured in an input register, decided combinationally by the
// decode logic against the queue state, and lands in an output register; the
// queue pointers, mode identifier and valid flag update in that same cycle, so
// the next frame sees them with no bubble. The outgoing queue holds 16 frames
// in flip-flops and needs no clearing pass after reset. The output register
// decouples the two sides: a finished result may wait while a new frame is
// already taken into the input register. Write the two mode registers only
// while no frame is in flight.
module arm_can_link_frame_handler (
  input  logic                     clk,
  input  logic                     rst,
  acl_frame_if.sink                frame,
  acl_result_if.source             result,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [acl_pkg::ID_W-1:0] cfg_data
);

  // configuration and architectural state
  logic [acl_pkg::ID_W-1:0] cartesian_mode_id;
  logic [acl_pkg::ID_W-1:0] joint_mode_id;
  logic [acl_pkg::ID_W-1:0] mode_id;
  logic                     valid_flag;

  // input register
  logic                       in_valid;
  logic                       in_command;
  logic [acl_pkg::ID_W-1:0]   in_id;
  logic [acl_pkg::LEN_W-1:0]  in_len;
  logic [acl_pkg::DATA_W-1:0] in_data;

  // output register
  logic             out_valid;
  acl_pkg::result_t out_res;

  acl_pkg::ctrl_t   ctrl;
  acl_pkg::ctrl_t   ctrl_fire;
  acl_pkg::qstat_t  qstat;
  acl_pkg::result_t res;
  logic             fire;

  // advance the held frame when the output register is free or being drained
  assign fire        = in_valid && (!out_valid || result.ready);
  assign frame.ready = !in_valid || fire;
  assign ctrl_fire   = fire ? ctrl : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cartesian_mode_id <= acl_pkg::CARTESIAN_RESET;
      joint_mode_id     <= acl_pkg::JOINT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == acl_pkg::CFG_CARTESIAN) begin
        cartesian_mode_id <= cfg_data;
      end else begin
        joint_mode_id <= cfg_data;
      end
    end
  end

  // every outgoing frame sets the mode; the valid flag only ever rises
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_id    <= '0;
      valid_flag <= 1'b0;
    end else begin
      if (ctrl_fire.mode_we) begin
        mode_id <= in_id;
      end
      if (ctrl_fire.valid_set) begin
        valid_flag <= 1'b1;
      end
    end
  end

  // input register: hold until the decode stage takes the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_command <= frame.command;
      in_id      <= frame.frame_id;
      in_len     <= frame.frame_len;
      in_data    <= frame.frame_data;
    end
  end

  acl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl_fire),
    .push_id   (in_id),
    .push_data (in_data),
    .qstat     (qstat)
  );

  acl_decode u_decode (
    .command           (in_command),
    .frame_id          (in_id),
    .frame_len         (in_len),
    .frame_data        (in_data),
    .cartesian_mode_id (cartesian_mode_id),
    .joint_mode_id     (joint_mode_id),
    .mode_id           (mode_id),
    .valid_flag        (valid_flag),
    .qstat             (qstat),
    .ctrl              (ctrl),
    .res               (res)
  );

  // output register: load on fire, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.result_kind  = out_res.kind;
  assign result.pos_a        = out_res.pos_a;
  assign result.pos_b        = out_res.pos_b;
  assign result.pos_c        = out_res.pos_c;
  assign result.pos_d        = out_res.pos_d;
  assign result.status_code  = out_res.status_code;
  assign result.message_code = out_res.message_code;
  assign result.state_valid  = out_res.state_valid;
  assign result.tx_valid     = out_res.tx_valid;
  assign result.tx_id        = out_res.tx_id;
  assign result.tx_len       = out_res.tx_len;
  assign result.tx_data      = out_res.tx_data;

endmodule

>>> tb/sv/arm_can_link_frame_handler_tb.sv
`timescale 1ns / 100ps
// Testbench for arm_can_link_frame_handler: directed and random frames against a predictor.
// Depends on acl_pkg and on the acl_frame_if / acl_result_if interfaces.
module arm_can_link_frame_handler_tb;
  import acl_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 8;
  // Wait after the last result before touching the mode registers or closing the run.
  localparam int SETTLE_CYCLES = 6;
  // Watchdog time limit, well above what the slowest honest run needs.
  localparam longint LIMIT_NS = 64'd200000 * CLK_PERIOD;
  localparam int PHASE_ITEMS = 175;
  localparam logic CMD_RECEIVE = ~CMD_ENQUEUE;

  // Scoreboard: mirrors the outgoing queue, mode identifier and valid flag,
  // and keeps the results that accepted frames must produce, oldest first.
  class link_scoreboard;
    logic [ID_W-1:0]   fifo_id[QUEUE_DEPTH];
    logic [LEN_W-1:0]  fifo_len[QUEUE_DEPTH];
    logic [DATA_W-1:0] fifo_data[QUEUE_DEPTH];
    int                fifo_head;
    int                fifo_tail;
    int                fifo_count;
    logic [ID_W-1:0]   mode;
    logic              position_valid;
    logic [ID_W-1:0]   cartesian_id;
    logic [ID_W-1:0]   joint_id;
    result_t           awaited_results[$];
    int                errors;
    int                frames;
    int                kind_count[7];
    int                tx_count;

    function new();
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        fifo_id[i] = '0;
        fifo_len[i] = '0;
        fifo_data[i] = '0;
      end
      fifo_head = 0;
      fifo_tail = 0;
      fifo_count = 0;
      mode = '0;
      position_valid = 1'b0;
      cartesian_id = CARTESIAN_RESET;
      joint_id = JOINT_RESET;
      errors = 0;
      frames = 0;
      tx_count = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    function void set_mode_ids(logic [ID_W-1:0] cart, logic [ID_W-1:0] joint);
      cartesian_id = cart;
      joint_id = joint;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Big-endian byte pair starting at byte k, as a signed position.
    function logic signed [POS_W-1:0] pos_pair(logic [DATA_W-1:0] data, int k);
      return {data[8*k +: 8], data[8*(k+1) +: 8]};
    endfunction

    // Work out the result of one accepted frame and advance the mirrored state.
    function void note_frame(logic cmd, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                             logic [DATA_W-1:0] data);
      result_t want;
      int      newest;
      logic    motion;
      want = '0;
      if (cmd == CMD_ENQUEUE) begin
        motion = (id == cartesian_id) || (id == joint_id);
        mode = id;
        newest = (fifo_tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        if (fifo_count > 0 && motion && fifo_id[newest] == id &&
            fifo_data[newest][CMP_W-1:0] == data[CMP_W-1:0]) begin
          want.kind = KIND_DUPLICATE;
        end else if (fifo_count >= QUEUE_DEPTH) begin
          want.kind = KIND_FULL;
        end else begin
          fifo_id[fifo_tail] = id;
          fifo_len[fifo_tail] = (len > LEN_MAX) ? LEN_MAX : len;
          fifo_data[fifo_tail] = data;
          fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
          fifo_count++;
          want.kind = KIND_QUEUED;
        end
      end else if (id == ID_GROUP_ONE) begin
        want.kind = KIND_GROUP_ONE;
        want.pos_a = pos_pair(data, 2);
        want.pos_b = pos_pair(data, 4);
        want.pos_c = pos_pair(data, 6);
        want.status_code = data[7:0];
        want.message_code = data[15:8];
      end else if (id == ID_GROUP_TWO) begin
        want.kind = KIND_GROUP_TWO;
        want.pos_a = pos_pair(data, 0);
        want.pos_b = pos_pair(data, 2);
        want.pos_c = pos_pair(data, 4);
        want.pos_d = pos_pair(data, 6);
        if (mode == cartesian_id || mode == joint_id) position_valid = 1'b1;
      end else if (id == ID_POLL) begin
        want.kind = KIND_TRANSMIT;
        if (fifo_count > 0) begin
          want.tx_valid = 1'b1;
          want.tx_id = fifo_id[fifo_head];
          want.tx_len = fifo_len[fifo_head];
          want.tx_data = fifo_data[fifo_head];
          fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
          fifo_count--;
          tx_count++;
        end
      end else begin
        want.kind = KIND_UNKNOWN;
      end
      want.state_valid = position_valid;
      kind_count[want.kind]++;
      frames++;
      awaited_results.push_back(want);
    endfunction

    task report(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report("result_kind (nothing outstanding)", got.kind, '0);
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) report("result_kind", got.kind, want.kind);
      if (got.pos_a !== want.pos_a) report("pos_a", got.pos_a, want.pos_a);
      if (got.pos_b !== want.pos_b) report("pos_b", got.pos_b, want.pos_b);
      if (got.pos_c !== want.pos_c) report("pos_c", got.pos_c, want.pos_c);
      if (got.pos_d !== want.pos_d) report("pos_d", got.pos_d, want.pos_d);
      if (got.status_code !== want.status_code)
        report("status_code", got.status_code, want.status_code);
      if (got.message_code !== want.message_code)
        report("message_code", got.message_code, want.message_code);
      if (got.state_valid !== want.state_valid)
        report("state_valid", got.state_valid, want.state_valid);
      if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
      if (got.tx_id !== want.tx_id) report("tx_id", got.tx_id, want.tx_id);
      if (got.tx_len !== want.tx_len) report("tx_len", got.tx_len, want.tx_len);
      if (got.tx_data !== want.tx_data) report("tx_data", got.tx_data, want.tx_data);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [ID_W-1:0]   cfg_data;

  // Idling on both sides is switched off for the last phase.
  bit                idle_on = 1'b1;
  // Mode registers as currently programmed, for shaping motion frames.
  logic [ID_W-1:0]   cartesian_now = CARTESIAN_RESET;
  logic [ID_W-1:0]   joint_now = JOINT_RESET;
  // Last frame offered for queueing, the seed of duplicate attempts.
  logic [ID_W-1:0]   last_enq_id = '0;
  logic [DATA_W-1:0] last_enq_data = '0;
  bit                have_last = 1'b0;

  link_scoreboard    sb = new();

  acl_frame_if  frame_if();
  acl_result_if result_if();

  arm_can_link_frame_handler u_top (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame_if),
    .result   (result_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("arm_can_link_frame_handler verification failed");
    $finish;
  end

  // Result side: drop ready at random while idling is on.
  initial begin
    int hold;
    hold = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        result_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 7);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Sample every accepted result at the rising edge and check it.
  always @(posedge clk) begin
    result_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = '0;
      got.kind = result_kind_t'(result_if.result_kind);
      got.pos_a = result_if.pos_a;
      got.pos_b = result_if.pos_b;
      got.pos_c = result_if.pos_c;
      got.pos_d = result_if.pos_d;
      got.status_code = result_if.status_code;
      got.message_code = result_if.message_code;
      got.state_valid = result_if.state_valid;
      got.tx_valid = result_if.tx_valid;
      got.tx_id = result_if.tx_id;
      got.tx_len = result_if.tx_len;
      got.tx_data = result_if.tx_data;
      sb.check_result(got);
    end
  end

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // Offer one frame item; returns at the falling edge after it was accepted.
  // Valid stays high on return so back-to-back items leave no bubble.
  task automatic send_frame(logic cmd, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                            logic [DATA_W-1:0] data);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    frame_if.valid <= 1'b1;
    frame_if.command <= cmd;
    frame_if.frame_id <= id;
    frame_if.frame_len <= len;
    frame_if.frame_data <= data;
    do @(posedge clk); while (!frame_if.ready);
    sb.note_frame(cmd, id, len, data);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic wait_idle();
    frame_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Program both mode registers on consecutive edges; only call while idle.
  task automatic write_mode_ids(logic [ID_W-1:0] cart, logic [ID_W-1:0] joint);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CARTESIAN;
    cfg_data <= cart;
    @(negedge clk);
    cfg_index <= CFG_JOINT;
    cfg_data <= joint;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_mode_ids(cart, joint);
    cartesian_now = cart;
    joint_now = joint;
  endtask

  // Directed frames under the reset mode ids (cartesian 1, joint 4).
  task automatic run_directed();
    logic [DATA_W-1:0] pattern;
    pattern = 64'h8877_6655_4433_2211;
    // Group two before any motion mode: positions all -1, valid stays low.
    send_frame(CMD_RECEIVE, ID_GROUP_TWO, 4'd8, '1);
    send_frame(CMD_RECEIVE, ID_POLL, 4'd0, '0);            // poll on empty queue
    // Group one with status/message bytes and +max, -max, -1 positions.
    send_frame(CMD_RECEIVE, ID_GROUP_ONE, 4'd15, 64'hFFFF_0080_FF7F_5AA5);
    send_frame(CMD_RECEIVE, ID_GROUP_ONE, 4'd0, '0);
    send_frame(CMD_RECEIVE, 11'd0, 4'd8, pattern);          // unknown ids at both ends
    send_frame(CMD_RECEIVE, 11'h7FF, 4'd8, pattern);
    // Non-motion frame with overlong length: stored as length 8.
    send_frame(CMD_ENQUEUE, 11'h7FF, 4'd15, '1);
    send_frame(CMD_RECEIVE, ID_GROUP_TWO, 4'd8, pattern);   // mode not motion yet
    send_frame(CMD_ENQUEUE, CARTESIAN_RESET, 4'd8, pattern);
    // Same id and bytes 0-5, other length and bytes 6-7: dropped as repeat.
    send_frame(CMD_ENQUEUE, CARTESIAN_RESET, 4'd3, {16'h0BAD, pattern[47:0]});
    // Byte 5 differs: queued.
    send_frame(CMD_ENQUEUE, CARTESIAN_RESET, 4'd8, pattern ^ (64'd1 << 40));
    send_frame(CMD_ENQUEUE, JOINT_RESET, 4'd8, pattern ^ (64'd1 << 40));
    send_frame(CMD_ENQUEUE, JOINT_RESET, 4'd1, pattern ^ (64'd1 << 40));
    // Repeated non-motion frame is queued twice and leaves the mode non-motion.
    send_frame(CMD_ENQUEUE, ID_GROUP_ONE, 4'd0, '0);
    send_frame(CMD_ENQUEUE, ID_GROUP_ONE, 4'd0, '0);
    send_frame(CMD_RECEIVE, ID_GROUP_TWO, 4'd8, pattern);
    send_frame(CMD_ENQUEUE, JOINT_RESET, 4'd9, ~pattern);
    // Motion mode now: group two raises the valid flag; received length ignored.
    send_frame(CMD_RECEIVE, ID_GROUP_TWO, 4'd15, 64'h8000_7FFF_0001_FFFE);
    // Drain the seven queued frames, then one more poll on the empty queue.
    repeat (8) send_frame(CMD_RECEIVE, ID_POLL, 4'($urandom_range(0, 15)), rand_data());
  endtask

  // Random traffic: runs of queued frames (with repeats of the newest one),
  // runs of polls, position frames and odd frames mixed in.
  task automatic run_random(int n_items);
    int                sent;
    int                burst;
    int                pick;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      burst = $urandom_range(1, 20);
      if (pick < 30) begin
        repeat (burst) begin
          if (have_last && $urandom_range(0, 2) == 0) begin
            // Repeat the newest frame with fresh bytes 6-7; sometimes break
            // the repeat with one flipped bit in bytes 0-5.
            id = last_enq_id;
            data = {16'($urandom), last_enq_data[CMP_W-1:0]};
            if ($urandom_range(0, 3) == 0) data[$urandom_range(0, CMP_W - 1)] ^= 1'b1;
          end else begin
            if ($urandom_range(0, 4) == 0) id = 11'($urandom_range(0, 2047));
            else id = $urandom_range(0, 1) ? cartesian_now : joint_now;
            data = rand_data();
          end
          send_frame(CMD_ENQUEUE, id, 4'($urandom_range(0, 15)), data);
          last_enq_id = id;
          last_enq_data = data;
          have_last = 1'b1;
        end
        sent += burst;
      end else if (pick < 60) begin
        repeat (burst) send_frame(CMD_RECEIVE, ID_POLL, 4'($urandom_range(0, 15)), rand_data());
        sent += burst;
      end else if (pick < 85) begin
        burst = $urandom_range(1, 4);
        repeat (burst)
          send_frame(CMD_RECEIVE, $urandom_range(0, 1) ? ID_GROUP_ONE : ID_GROUP_TWO,
                     4'($urandom_range(0, 15)), rand_data());
        sent += burst;
      end else begin
        send_frame(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                   4'($urandom_range(0, 15)), rand_data());
        sent++;
      end
    end
  endtask

  initial begin
    logic [ID_W-1:0] shared_id;
    // Drive every input to a known value before the first edge.
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_CARTESIAN;
    cfg_data = '0;
    frame_if.valid = 1'b0;
    frame_if.command = CMD_ENQUEUE;
    frame_if.frame_id = '0;
    frame_if.frame_len = '0;
    frame_if.frame_data = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    wait_idle();

    // Extreme mode ids, both ways round.
    write_mode_ids(11'd0, 11'h7FF);
    run_random(PHASE_ITEMS);
    wait_idle();
    write_mode_ids(11'h7FF, 11'd0);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Both motion ids the same.
    shared_id = 11'($urandom_range(0, 2047));
    write_mode_ids(shared_id, shared_id);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Random ids, and no idling on either side for the final stretch.
    write_mode_ids(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
    idle_on = 1'b0;
    run_random(PHASE_ITEMS);
    wait_idle();

    $display("Checked %0d frames: queued %0d, repeats dropped %0d, queue full %0d",
             sb.frames, sb.kind_count[KIND_QUEUED], sb.kind_count[KIND_DUPLICATE],
             sb.kind_count[KIND_FULL]);
    $display("  group one %0d, group two %0d, polls %0d (%0d sent), unknown %0d",
             sb.kind_count[KIND_GROUP_ONE], sb.kind_count[KIND_GROUP_TWO],
             sb.kind_count[KIND_TRANSMIT], sb.tx_count, sb.kind_count[KIND_UNKNOWN]);
    if (sb.errors == 0) begin
      $display("arm_can_link_frame_handler verification clean");
    end else begin
      $display("arm_can_link_frame_handler verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/acl_pkg.sv
rtl/acl_if.sv
rtl/acl_queue.sv
rtl/acl_decode.sv
rtl/arm_can_link_frame_handler.sv
tb/sv/arm_can_link_frame_handler_tb.sv
